// File: rtl/rtss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtss_pkg
// Shared sizes, codes and types for the return target shadow stack.
// ----------------------------------------------------------------------------
package rtss_pkg;

	localparam int BUCKETS      = 512;
	localparam int STACK_DEPTH  = 64;
	localparam int PAIR_ENTRIES = 1024;

	localparam int ADDR_W = 32;
	localparam int ACT_W  = 2;
	localparam int STAT_W = 3;

	// bucket index, pair link (index + 1, 0 = none), pair index
	localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int LINK_W = $clog2(PAIR_ENTRIES + 1);
	localparam int IDX_W  = $clog2(PAIR_ENTRIES);
	// stack fill level and slot address
	localparam int TOP_W  = $clog2(STACK_DEPTH + 1);
	localparam int SP_W   = $clog2(STACK_DEPTH);

	typedef logic [ACT_W-1:0] action_t;
	localparam action_t ACT_SET  = 2'd0;
	localparam action_t ACT_PUSH = 2'd1;
	localparam action_t ACT_POP  = 2'd2;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE      = 3'd0,
		ST_HIT       = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_MISMATCH  = 3'd3,
		ST_NOTARGET  = 3'd4,
		ST_MAPFULL   = 3'd5,
		ST_STACKFULL = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_HASH,
		S_HEAD,
		S_WALK,
		S_POP_SLOT,
		S_POP_PAIR,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] guest;
		logic [ADDR_W-1:0] host;
		logic [LINK_W-1:0] next;
	} pair_t;

endpackage
`default_nettype wire

// File: rtl/return_target_shadow_stack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// return_target_shadow_stack
// Shadow return stack over a hashed guest-to-host address map.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------
//  item     | item_valid / item_stall    | action, guest_addr, host_addr
//  result   | result_valid / result_stall| status, host_target
//
// One item at a time. Set and push hash the guest address, read the bucket
// head and then walk the chain in the pair RAM one entry at a time; a bucket
// count that is not a power of two is hashed serially. Pop reads the stack
// slot and then the pair; an empty pop, a full stack and an unknown action
// finish straight from dispatch. After reset a clearing pass writes every
// bucket head, one per cycle, with item_stall held high.
// A result waiting under result_stall does not block the next transfer in.
// ----------------------------------------------------------------------------
module return_target_shadow_stack (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	output logic                              item_stall,
	input  wire logic [rtss_pkg::ACT_W-1:0]   action,
	input  wire logic [rtss_pkg::ADDR_W-1:0]  guest_addr,
	input  wire logic [rtss_pkg::ADDR_W-1:0]  host_addr,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output logic      [rtss_pkg::STAT_W-1:0]  status,
	output logic      [rtss_pkg::ADDR_W-1:0]  host_target
);

	localparam int LW = rtss_pkg::LINK_W;
	localparam int IW = rtss_pkg::IDX_W;
	localparam int TW = rtss_pkg::TOP_W;
	localparam int SW = rtss_pkg::SP_W;
	localparam int BW = rtss_pkg::BKT_W;
	localparam int AW = rtss_pkg::ADDR_W;
	localparam int PW = $bits(rtss_pkg::pair_t);

	rtss_pkg::state_t   state_q, state_d;
	logic [BW-1:0]      clr_q;
	rtss_pkg::action_t  act_q;
	logic [AW-1:0]      guest_q, host_q;
	logic [LW-1:0]      link_q, link_d, head_q, head_cur;
	logic [LW-1:0]      pair_count_q;
	logic [TW-1:0]      stack_top_q, top_m1;
	rtss_pkg::status_t  pend_status_q, fin_status;
	logic [AW-1:0]      pend_target_q, fin_target;
	logic               result_valid_q;
	rtss_pkg::status_t  status_q;
	logic [AW-1:0]      host_target_q;

	logic               fin, found, miss, head_ld, cnt_inc, top_inc, top_dec;
	logic               out_free;

	// bucket hash
	logic               hash_start, hash_done;
	logic [BW-1:0]      bucket;

	// bucket head RAM
	logic               bkt_we, bkt_re;
	logic [BW-1:0]      bkt_waddr;
	logic [LW-1:0]      bkt_wdata, bkt_rd;

	// pair RAM
	logic               pair_we, pair_re;
	logic [IW-1:0]      pair_waddr, pair_raddr;
	rtss_pkg::pair_t    pair_wdata, pair_rd;
	logic [PW-1:0]      pair_rd_raw;
	logic [LW-1:0]      pair_sel_link, pair_sel_m1, link_m1;

	// stack RAM
	logic               stk_we, stk_re;
	logic [SW-1:0]      stk_waddr;
	logic [IW-1:0]      stk_wdata, stk_rd;

	rtss_bucket u_bucket (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.guest  (guest_q),
		.done   (hash_done),
		.bucket (bucket)
	);

	rtss_ram #(.WIDTH(LW), .DEPTH(rtss_pkg::BUCKETS)) u_bucket_ram (
		.clk     (clk),
		.wr_en   (bkt_we),
		.wr_addr (bkt_waddr),
		.wr_data (bkt_wdata),
		.rd_en   (bkt_re),
		.rd_addr (bucket),
		.rd_data (bkt_rd)
	);

	rtss_ram #(.WIDTH(PW), .DEPTH(rtss_pkg::PAIR_ENTRIES)) u_pair_ram (
		.clk     (clk),
		.wr_en   (pair_we),
		.wr_addr (pair_waddr),
		.wr_data (pair_wdata),
		.rd_en   (pair_re),
		.rd_addr (pair_raddr),
		.rd_data (pair_rd_raw)
	);

	rtss_ram #(.WIDTH(IW), .DEPTH(rtss_pkg::STACK_DEPTH)) u_stack_ram (
		.clk     (clk),
		.wr_en   (stk_we),
		.wr_addr (stk_waddr),
		.wr_data (stk_wdata),
		.rd_en   (stk_re),
		.rd_addr (top_m1[SW-1:0]),
		.rd_data (stk_rd)
	);

	assign pair_rd  = rtss_pkg::pair_t'(pair_rd_raw);
	assign top_m1   = stack_top_q - TW'(1);
	assign link_m1  = link_q - LW'(1);
	assign head_cur = (state_q == rtss_pkg::S_HEAD) ? bkt_rd : head_q;
	assign out_free = !result_valid_q || !result_stall;

	// next pair link to follow: the chain head first, then each next field
	assign pair_sel_link = (state_q == rtss_pkg::S_HEAD) ? bkt_rd : pair_rd.next;
	assign pair_sel_m1   = pair_sel_link - LW'(1);

	always_comb begin
		state_d    = state_q;
		hash_start = 1'b0;
		bkt_we     = 1'b0;
		bkt_waddr  = bucket;
		bkt_wdata  = '0;
		bkt_re     = 1'b0;
		pair_we    = 1'b0;
		pair_waddr = pair_count_q[IW-1:0];
		pair_wdata = '{guest: guest_q, host: '0, next: head_cur};
		pair_re    = 1'b0;
		pair_raddr = pair_sel_m1[IW-1:0];
		stk_we     = 1'b0;
		stk_waddr  = stack_top_q[SW-1:0];
		stk_wdata  = '0;
		stk_re     = 1'b0;
		fin        = 1'b0;
		fin_status = rtss_pkg::ST_DONE;
		fin_target = '0;
		found      = 1'b0;
		miss       = 1'b0;
		link_d     = link_q;
		head_ld    = 1'b0;
		cnt_inc    = 1'b0;
		top_inc    = 1'b0;
		top_dec    = 1'b0;

		unique case (state_q)
			rtss_pkg::S_CLEAR: begin
				bkt_we    = 1'b1;
				bkt_waddr = clr_q;
				if (clr_q == BW'(rtss_pkg::BUCKETS - 1)) begin
					state_d = rtss_pkg::S_IDLE;
				end
			end
			rtss_pkg::S_IDLE: begin
				if (item_valid) begin
					state_d = rtss_pkg::S_DISPATCH;
				end
			end
			rtss_pkg::S_DISPATCH: begin
				case (act_q)
					rtss_pkg::ACT_SET: begin
						hash_start = 1'b1;
						state_d    = rtss_pkg::S_HASH;
					end
					rtss_pkg::ACT_PUSH: begin
						if (stack_top_q >= TW'(rtss_pkg::STACK_DEPTH)) begin
							fin        = 1'b1;
							fin_status = rtss_pkg::ST_STACKFULL;
						end else begin
							hash_start = 1'b1;
							state_d    = rtss_pkg::S_HASH;
						end
					end
					rtss_pkg::ACT_POP: begin
						if (stack_top_q == '0) begin
							fin        = 1'b1;
							fin_status = rtss_pkg::ST_EMPTY;
						end else begin
							stk_re  = 1'b1;
							top_dec = 1'b1;
							state_d = rtss_pkg::S_POP_SLOT;
						end
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			rtss_pkg::S_HASH: begin
				if (hash_done) begin
					bkt_re  = 1'b1;
					state_d = rtss_pkg::S_HEAD;
				end
			end
			rtss_pkg::S_HEAD: begin
				head_ld = 1'b1;
				if (bkt_rd == '0 || bkt_rd > pair_count_q) begin
					miss = 1'b1;
				end else begin
					pair_re = 1'b1;
					link_d  = bkt_rd;
					state_d = rtss_pkg::S_WALK;
				end
			end
			rtss_pkg::S_WALK: begin
				if (pair_rd.guest == guest_q) begin
					found = 1'b1;
				end else if (pair_rd.next == '0 || pair_rd.next > pair_count_q) begin
					miss = 1'b1;
				end else begin
					pair_re = 1'b1;
					link_d  = pair_rd.next;
				end
			end
			rtss_pkg::S_POP_SLOT: begin
				pair_raddr = stk_rd;
				if (LW'(stk_rd) >= LW'(rtss_pkg::PAIR_ENTRIES)) begin
					fin        = 1'b1;
					fin_status = rtss_pkg::ST_MISMATCH;
				end else begin
					pair_re = 1'b1;
					state_d = rtss_pkg::S_POP_PAIR;
				end
			end
			rtss_pkg::S_POP_PAIR: begin
				fin = 1'b1;
				if (pair_rd.guest != guest_q) begin
					fin_status = rtss_pkg::ST_MISMATCH;
				end else if (pair_rd.host == '0) begin
					fin_status = rtss_pkg::ST_NOTARGET;
				end else begin
					fin_status = rtss_pkg::ST_HIT;
					fin_target = pair_rd.host;
				end
			end
			rtss_pkg::S_FINISH: begin
				if (out_free) begin
					state_d = rtss_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rtss_pkg::S_IDLE;
			end
		endcase

		// pair found: update its target, or push its index
		if (found) begin
			fin = 1'b1;
			if (act_q == rtss_pkg::ACT_SET) begin
				pair_we    = 1'b1;
				pair_waddr = link_m1[IW-1:0];
				pair_wdata = '{guest: pair_rd.guest, host: host_q, next: pair_rd.next};
			end else begin
				stk_we    = 1'b1;
				stk_wdata = link_m1[IW-1:0];
				top_inc   = 1'b1;
			end
		end

		// pair absent: insert at the chain head when the store has room, and push it for a push
		if (miss) begin
			fin = 1'b1;
			if (pair_count_q >= LW'(rtss_pkg::PAIR_ENTRIES)) begin
				fin_status = rtss_pkg::ST_MAPFULL;
			end else begin
				pair_we    = 1'b1;
				pair_wdata = '{guest: guest_q,
				               host: (act_q == rtss_pkg::ACT_SET) ? host_q : '0,
				               next: head_cur};
				bkt_we     = 1'b1;
				bkt_wdata  = pair_count_q + LW'(1);
				cnt_inc    = 1'b1;
				if (act_q == rtss_pkg::ACT_PUSH) begin
					stk_we    = 1'b1;
					stk_wdata = pair_count_q[IW-1:0];
					top_inc   = 1'b1;
				end
			end
		end

		if (fin) begin
			state_d = rtss_pkg::S_FINISH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= rtss_pkg::S_CLEAR;
			clr_q          <= '0;
			pair_count_q   <= '0;
			stack_top_q    <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rtss_pkg::S_CLEAR) begin
				clr_q <= clr_q + BW'(1);
			end
			if (cnt_inc) begin
				pair_count_q <= pair_count_q + LW'(1);
			end
			if (top_inc) begin
				stack_top_q <= stack_top_q + TW'(1);
			end else if (top_dec) begin
				stack_top_q <= top_m1;
			end
			if (state_q == rtss_pkg::S_FINISH && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rtss_pkg::S_IDLE && item_valid) begin
			act_q   <= action;
			guest_q <= guest_addr;
			host_q  <= host_addr;
		end
		link_q <= link_d;
		if (head_ld) begin
			head_q <= bkt_rd;
		end
		if (fin) begin
			pend_status_q <= fin_status;
			pend_target_q <= fin_target;
		end
		// hold the result until the transfer out
		if (state_q == rtss_pkg::S_FINISH && out_free) begin
			status_q      <= pend_status_q;
			host_target_q <= pend_target_q;
		end
	end

	assign item_stall   = (state_q != rtss_pkg::S_IDLE);
	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign host_target  = host_target_q;

endmodule
`default_nettype wire

// File: rtl/rtss_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtss_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rtss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                            clk,
	input  wire logic                                            wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0]                                wr_data,
	input  wire logic                                            rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    rd_addr,
	output logic      [WIDTH-1:0]                                rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/rtss_bucket.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtss_bucket
// Hash bucket of a guest address: guest mod bucket count. A power-of-two
// count is a mask; any other count is reduced one nibble per cycle.
// ----------------------------------------------------------------------------
module rtss_bucket (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [rtss_pkg::ADDR_W-1:0] guest,
	output logic                            done,
	output logic      [rtss_pkg::BKT_W-1:0] bucket
);

	localparam int  BW   = rtss_pkg::BKT_W;
	localparam bit  POW2 = (rtss_pkg::BUCKETS & (rtss_pkg::BUCKETS - 1)) == 0;
	localparam int  RW   = BW + 4;
	localparam int  NIBS = rtss_pkg::ADDR_W / 4;
	localparam int  CW   = $clog2(NIBS);

	generate
		if (POW2) begin : g_mask
			assign bucket = BW'(guest & rtss_pkg::ADDR_W'(rtss_pkg::BUCKETS - 1));
			assign done   = 1'b1;
		end else begin : g_serial
			logic                          busy_q;
			logic [CW-1:0]                 cnt_q;
			logic [rtss_pkg::ADDR_W-1:0]   shift_q;
			logic [BW-1:0]                 rem_q;
			logic [RW-1:0]                 acc;

			// fold in the next nibble and bring the remainder back below the count
			always_comb begin
				acc = {rem_q, shift_q[rtss_pkg::ADDR_W-1 -: 4]};
				for (int k = 3; k >= 0; k--) begin
					if (acc >= (RW'(rtss_pkg::BUCKETS) << k)) begin
						acc = acc - (RW'(rtss_pkg::BUCKETS) << k);
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					cnt_q  <= '0;
				end else if (start) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end else if (busy_q) begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(NIBS - 1)) begin
						busy_q <= 1'b0;
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					shift_q <= guest;
					rem_q   <= '0;
				end else if (busy_q) begin
					shift_q <= shift_q << 4;
					rem_q   <= acc[BW-1:0];
				end
			end

			assign bucket = rem_q;
			assign done   = !busy_q;
		end
	endgenerate

endmodule
`default_nettype wire
